FILE: src/qaa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qaa_pkg;

    localparam int ANG_STEPS = 20;
    localparam int SQ_STEPS  = 29;
    localparam int VW        = 40;
    localparam int AW        = 26;
    localparam int RW        = 34;
    localparam int SQW       = 58;

    localparam logic signed [AW-1:0] PI_Q20      = 26'sd3294199;
    localparam logic signed [AW-1:0] HALF_PI_Q20 = 26'sd1647099;
    localparam logic signed [RW-1:0] CORDIC_K    = 34'sd652032874;

    localparam logic [1:0] REG_INV_MASS    = 2'd0;
    localparam logic [1:0] REG_THRUST_GAIN = 2'd1;
    localparam logic [1:0] REG_GRAVITY     = 2'd2;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] z;
        logic                 zero;
    } t_vec;

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [AW-1:0] a;
        logic                 neg;
    } t_rot;

    typedef struct packed {
        logic [SQW-1:0] v;
        logic [SQW-1:0] r;
    } t_sqrt;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } t_ang;

    function automatic logic signed [AW-1:0] atan_tab(input int i);
        case (i)
            0:       return 26'sd823550;
            1:       return 26'sd486170;
            2:       return 26'sd256879;
            3:       return 26'sd130396;
            4:       return 26'sd65451;
            5:       return 26'sd32757;
            6:       return 26'sd16383;
            7:       return 26'sd8192;
            8:       return 26'sd4096;
            9:       return 26'sd2048;
            10:      return 26'sd1024;
            11:      return 26'sd512;
            12:      return 26'sd256;
            13:      return 26'sd128;
            14:      return 26'sd64;
            15:      return 26'sd32;
            16:      return 26'sd16;
            17:      return 26'sd8;
            18:      return 26'sd4;
            19:      return 26'sd2;
            default: return '0;
        endcase
    endfunction

    // vectoring start: left half-plane folded over with a pi preload
    function automatic t_vec vec_init(input logic signed [VW-1:0] x,
                                      input logic signed [VW-1:0] y);
        t_vec v;
        v.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            v.x = -x;
            v.y = -y;
            v.z = (y >= 0) ? PI_Q20 : -PI_Q20;
        end else begin
            v.x = x;
            v.y = y;
            v.z = '0;
        end
        return v;
    endfunction

    function automatic t_vec vec_step(input t_vec v, input int i);
        t_vec n;
        n = v;
        if (v.y > 0) begin
            n.x = v.x + ($signed(v.y) >>> i);
            n.y = v.y - ($signed(v.x) >>> i);
            n.z = v.z + atan_tab(i);
        end else begin
            n.x = v.x - ($signed(v.y) >>> i);
            n.y = v.y + ($signed(v.x) >>> i);
            n.z = v.z - atan_tab(i);
        end
        return n;
    endfunction

    function automatic t_rot rot_init(input logic signed [AW-1:0] a);
        t_rot r;
        r.x = CORDIC_K;
        r.y = '0;
        if (a > HALF_PI_Q20) begin
            r.a   = a - PI_Q20;
            r.neg = 1'b1;
        end else if (a < -HALF_PI_Q20) begin
            r.a   = a + PI_Q20;
            r.neg = 1'b1;
        end else begin
            r.a   = a;
            r.neg = 1'b0;
        end
        return r;
    endfunction

    function automatic t_rot rot_step(input t_rot r, input int i);
        t_rot n;
        n = r;
        if (r.a >= 0) begin
            n.x = r.x - ($signed(r.y) >>> i);
            n.y = r.y + ($signed(r.x) >>> i);
            n.a = r.a - atan_tab(i);
        end else begin
            n.x = r.x + ($signed(r.y) >>> i);
            n.y = r.y - ($signed(r.x) >>> i);
            n.a = r.a + atan_tab(i);
        end
        return n;
    endfunction

    // one result bit of a floor square root
    function automatic t_sqrt sqrt_step(input t_sqrt s, input int k);
        t_sqrt          n;
        logic [SQW-1:0] b;
        logic [SQW-1:0] t;
        b = SQW'(1) << (2 * (SQ_STEPS - 1 - k));
        t = s.r + b;
        if (s.v >= t) begin
            n.v = s.v - t;
            n.r = (s.r >> 1) + b;
        end else begin
            n.v = s.v;
            n.r = s.r >> 1;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: src/quadrotor_attitude_acceleration.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle while the output is not stalled; a fully pipelined
// datapath with one square-root bit or CORDIC step per stage sets the depth.
// Reset (synchronous, active low) clears all valid bits and loads the register
// defaults; data stages are not reset.
module quadrotor_attitude_acceleration
    import qaa_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, rotor_cmd_0..3, 16 bits each
    input  wire logic [127:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // roll[15:0], pitch[30:16], yaw[46:31], acc_x[78:47], acc_y[110:79],
    // acc_z[142:111], zero pad
    output logic [143:0]      o_m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [23:0]  i_cfg_data
);

    localparam int NST = 81;

    logic [23:0] r_inv_mass;
    logic [15:0] r_thrust_gain;
    logic [20:0] r_gravity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass    <= 24'd65536;
            r_thrust_gain <= 16'd4096;
            r_gravity     <= 21'd642908;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INV_MASS:    r_inv_mass    <= i_cfg_data;
                REG_THRUST_GAIN: r_thrust_gain <= i_cfg_data[15:0];
                REG_GRAVITY:     r_gravity     <= i_cfg_data[20:0];
                default: ;
            endcase
        end
    end

    logic           en;
    logic [NST-1:0] r_v;

    assign en              = !r_v[NST-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST-2:0], i_s_axis_tvalid};
        end
    end

    // stage 1: quaternion products, command sum
    logic signed [15:0] qw, qx, qy, qz;
    assign qw = $signed(i_s_axis_tdata[15:0]);
    assign qx = $signed(i_s_axis_tdata[31:16]);
    assign qy = $signed(i_s_axis_tdata[47:32]);
    assign qz = $signed(i_s_axis_tdata[63:48]);

    logic signed [31:0] r1_wx, r1_yz, r1_xx, r1_yy, r1_wz, r1_xy, r1_zz, r1_wy, r1_xz;
    logic [17:0]        r1_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_wx  <= qw * qx;
            r1_yz  <= qy * qz;
            r1_xx  <= qx * qx;
            r1_yy  <= qy * qy;
            r1_wz  <= qw * qz;
            r1_xy  <= qx * qy;
            r1_zz  <= qz * qz;
            r1_wy  <= qw * qy;
            r1_xz  <= qx * qz;
            r1_sum <= 18'(i_s_axis_tdata[79:64]) + 18'(i_s_axis_tdata[95:80])
                    + 18'(i_s_axis_tdata[111:96]) + 18'(i_s_axis_tdata[127:112]);
        end
    end

    // stage 2: atan2 operands, clamped pitch term, force
    localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

    logic signed [32:0] n2_t;
    logic signed [28:0] n2_tc;
    logic signed [33:0] r2_ry_roll, r2_rx_roll, r2_ry_yaw, r2_rx_yaw;
    logic signed [28:0] r2_t;
    logic [33:0]        r2_force;

    always_comb begin
        n2_t = 33'(r1_wy) - 33'(r1_xz);
        if (n2_t > 33'sd134217728) begin
            n2_tc = 29'sd134217728;
        end else if (n2_t < -33'sd134217728) begin
            n2_tc = -29'sd134217728;
        end else begin
            n2_tc = 29'(n2_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ry_roll <= (34'(r1_wx) + 34'(r1_yz)) <<< 1;
            r2_rx_roll <= ONE_Q28 - ((34'(r1_xx) + 34'(r1_yy)) <<< 1);
            r2_ry_yaw  <= (34'(r1_wz) + 34'(r1_xy)) <<< 1;
            r2_rx_yaw  <= ONE_Q28 - ((34'(r1_yy) + 34'(r1_zz)) <<< 1);
            r2_t       <= n2_tc;
            r2_force   <= 34'(r1_sum) * 34'(r_thrust_gain);
        end
    end

    // square roots for pitch, roll and yaw vectoring in parallel
    logic signed [30:0] n_sp_arg, n_cp_arg;
    assign n_sp_arg = 31'sd268435456 + (31'(r2_t) <<< 1);
    assign n_cp_arg = 31'sd268435456 - (31'(r2_t) <<< 1);

    t_vec        r_a_roll [0:SQ_STEPS];
    t_vec        r_a_yaw  [0:SQ_STEPS];
    t_sqrt       r_a_sp   [0:SQ_STEPS];
    t_sqrt       r_a_cp   [0:SQ_STEPS];
    logic [57:0] r_a_acc  [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_roll[0] <= vec_init(40'(r2_rx_roll), 40'(r2_ry_roll));
            r_a_yaw[0]  <= vec_init(40'(r2_rx_yaw), 40'(r2_ry_yaw));
            r_a_sp[0]   <= '{v: {n_sp_arg[29:0], 28'd0}, r: '0};
            r_a_cp[0]   <= '{v: {n_cp_arg[29:0], 28'd0}, r: '0};
            r_a_acc[0]  <= 58'(r2_force) * 58'(r_inv_mass);
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_a
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_a_sp[k+1]  <= sqrt_step(r_a_sp[k], k);
                r_a_cp[k+1]  <= sqrt_step(r_a_cp[k], k);
                r_a_acc[k+1] <= r_a_acc[k];
                if (k < ANG_STEPS) begin
                    r_a_roll[k+1] <= vec_step(r_a_roll[k], k);
                    r_a_yaw[k+1]  <= vec_step(r_a_yaw[k], k);
                end else begin
                    r_a_roll[k+1] <= r_a_roll[k];
                    r_a_yaw[k+1]  <= r_a_yaw[k];
                end
            end
        end
    end

    // pitch vectoring
    logic [58:0] n_acc_rnd;
    assign n_acc_rnd = 59'(r_a_acc[SQ_STEPS]) + 59'd8388608;

    t_vec                 r_b_pitch [0:ANG_STEPS];
    logic signed [AW-1:0] r_b_roll  [0:ANG_STEPS];
    logic signed [AW-1:0] r_b_yaw   [0:ANG_STEPS];
    logic [34:0]          r_b_a16   [0:ANG_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_pitch[0] <= vec_init($signed(r_a_cp[SQ_STEPS].r[VW-1:0]),
                                     $signed(r_a_sp[SQ_STEPS].r[VW-1:0]));
            r_b_roll[0]  <= r_a_roll[SQ_STEPS].zero ? '0 : r_a_roll[SQ_STEPS].z;
            r_b_yaw[0]   <= r_a_yaw[SQ_STEPS].zero ? '0 : r_a_yaw[SQ_STEPS].z;
            r_b_a16[0]   <= n_acc_rnd[58:24];
        end
    end

    for (genvar k = 0; k < ANG_STEPS; k++) begin : g_b
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_b_pitch[k+1] <= vec_step(r_b_pitch[k], k);
                r_b_roll[k+1]  <= r_b_roll[k];
                r_b_yaw[k+1]   <= r_b_yaw[k];
                r_b_a16[k+1]   <= r_b_a16[k];
            end
        end
    end

    logic signed [AW-1:0] n_bz;
    logic signed [26:0]   r_pm_p21;
    logic signed [AW-1:0] r_pm_roll, r_pm_yaw;
    logic [34:0]          r_pm_a16;

    assign n_bz = r_b_pitch[ANG_STEPS].zero ? '0 : r_b_pitch[ANG_STEPS].z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pm_p21  <= (27'(n_bz) <<< 2) - 27'(PI_Q20);
            r_pm_roll <= r_b_roll[ANG_STEPS];
            r_pm_yaw  <= r_b_yaw[ANG_STEPS];
            r_pm_a16  <= r_b_a16[ANG_STEPS];
        end
    end

    // sine and cosine of the three angles
    logic signed [26:0] n_p20w;
    logic signed [26:0] n_rr, n_ry, n_rp;
    t_ang               n_ang;

    assign n_p20w = (r_pm_p21 + 27'sd1) >>> 1;
    assign n_rr   = (27'(r_pm_roll) + 27'sd64) >>> 7;
    assign n_ry   = (27'(r_pm_yaw) + 27'sd64) >>> 7;
    assign n_rp   = (r_pm_p21 + 27'sd128) >>> 8;

    always_comb begin
        n_ang.roll  = (n_rr > 27'sd25736) ? 16'sd25736 :
                      (n_rr < -27'sd25736) ? -16'sd25736 : 16'(n_rr);
        n_ang.yaw   = (n_ry > 27'sd25736) ? 16'sd25736 :
                      (n_ry < -27'sd25736) ? -16'sd25736 : 16'(n_ry);
        n_ang.pitch = (n_rp > 27'sd12868) ? 15'sd12868 :
                      (n_rp < -27'sd12868) ? -15'sd12868 : 15'(n_rp);
    end

    t_rot        r_c_r   [0:ANG_STEPS];
    t_rot        r_c_p   [0:ANG_STEPS];
    t_rot        r_c_y   [0:ANG_STEPS];
    t_ang        r_c_ang [0:ANG_STEPS];
    logic [34:0] r_c_a16 [0:ANG_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_r[0]   <= rot_init(r_pm_roll);
            r_c_p[0]   <= rot_init(AW'(n_p20w));
            r_c_y[0]   <= rot_init(r_pm_yaw);
            r_c_ang[0] <= n_ang;
            r_c_a16[0] <= r_pm_a16;
        end
    end

    for (genvar k = 0; k < ANG_STEPS; k++) begin : g_c
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_c_r[k+1]   <= rot_step(r_c_r[k], k);
                r_c_p[k+1]   <= rot_step(r_c_p[k], k);
                r_c_y[k+1]   <= rot_step(r_c_y[k], k);
                r_c_ang[k+1] <= r_c_ang[k];
                r_c_a16[k+1] <= r_c_a16[k];
            end
        end
    end

    function automatic logic signed [31:0] rot_sin(input t_rot r);
        return r.neg ? 32'(-r.y) : 32'(r.y);
    endfunction

    function automatic logic signed [31:0] rot_cos(input t_rot r);
        return r.neg ? 32'(-r.x) : 32'(r.x);
    endfunction

    function automatic logic signed [26:0] col_rnd(input logic signed [67:0] s);
        logic signed [37:0] t;
        logic signed [31:0] u;
        t = 38'((s + 68'sd536870912) >>> 30);
        u = 32'((t + 38'sd32) >>> 6);
        return 27'(u);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        if (v > 41'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -41'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return 32'(v);
        end
    endfunction

    // rotation column and scaling
    logic signed [31:0] n_sr, n_cr, n_sp, n_cp, n_sy, n_cy;
    assign n_sr = rot_sin(r_c_r[ANG_STEPS]);
    assign n_cr = rot_cos(r_c_r[ANG_STEPS]);
    assign n_sp = rot_sin(r_c_p[ANG_STEPS]);
    assign n_cp = rot_cos(r_c_p[ANG_STEPS]);
    assign n_sy = rot_sin(r_c_y[ANG_STEPS]);
    assign n_cy = rot_cos(r_c_y[ANG_STEPS]);

    logic signed [63:0] r_p1_crsp, r_p1_srsy, r_p1_srcy, r_p1_crcp;
    logic signed [31:0] r_p1_sy, r_p1_cy;
    t_ang               r_p1_ang;
    logic [34:0]        r_p1_a16;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_crsp <= n_cr * n_sp;
            r_p1_srsy <= n_sr * n_sy;
            r_p1_srcy <= n_sr * n_cy;
            r_p1_crcp <= n_cr * n_cp;
            r_p1_sy   <= n_sy;
            r_p1_cy   <= n_cy;
            r_p1_ang  <= r_c_ang[ANG_STEPS];
            r_p1_a16  <= r_c_a16[ANG_STEPS];
        end
    end

    logic signed [33:0] r_p2_crsp;
    logic signed [63:0] r_p2_srsy, r_p2_srcy, r_p2_crcp;
    logic signed [31:0] r_p2_sy, r_p2_cy;
    t_ang               r_p2_ang;
    logic [34:0]        r_p2_a16;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_crsp <= 34'((r_p1_crsp + 64'sd536870912) >>> 30);
            r_p2_srsy <= r_p1_srsy;
            r_p2_srcy <= r_p1_srcy;
            r_p2_crcp <= r_p1_crcp;
            r_p2_sy   <= r_p1_sy;
            r_p2_cy   <= r_p1_cy;
            r_p2_ang  <= r_p1_ang;
            r_p2_a16  <= r_p1_a16;
        end
    end

    logic signed [65:0] r_p3_cc, r_p3_cs;
    logic signed [63:0] r_p3_srsy, r_p3_srcy, r_p3_crcp;
    t_ang               r_p3_ang;
    logic [34:0]        r_p3_a16;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p3_cc   <= r_p2_crsp * r_p2_cy;
            r_p3_cs   <= r_p2_crsp * r_p2_sy;
            r_p3_srsy <= r_p2_srsy;
            r_p3_srcy <= r_p2_srcy;
            r_p3_crcp <= r_p2_crcp;
            r_p3_ang  <= r_p2_ang;
            r_p3_a16  <= r_p2_a16;
        end
    end

    logic signed [26:0] r_p4_c0, r_p4_c1, r_p4_c2;
    t_ang               r_p4_ang;
    logic [34:0]        r_p4_a16;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p4_c0  <= col_rnd(68'(r_p3_srsy) + 68'(r_p3_cc));
            r_p4_c1  <= col_rnd(68'(r_p3_cs) - 68'(r_p3_srcy));
            r_p4_c2  <= col_rnd(68'(r_p3_crcp));
            r_p4_ang <= r_p3_ang;
            r_p4_a16 <= r_p3_a16;
        end
    end

    logic signed [35:0] n_a16s;
    logic signed [62:0] r_p5_m0, r_p5_m1, r_p5_m2;
    t_ang               r_p5_ang;

    assign n_a16s = $signed({1'b0, r_p4_a16});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p5_m0  <= n_a16s * r_p4_c0;
            r_p5_m1  <= n_a16s * r_p4_c1;
            r_p5_m2  <= n_a16s * r_p4_c2;
            r_p5_ang <= r_p4_ang;
        end
    end

    logic signed [40:0] n_v0, n_v1, n_v2;
    assign n_v0 = 41'((r_p5_m0 + 63'sd8388608) >>> 24);
    assign n_v1 = 41'((r_p5_m1 + 63'sd8388608) >>> 24);
    assign n_v2 = 41'((r_p5_m2 + 63'sd8388608) >>> 24) - 41'(r_gravity);

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_m_axis_tdata <= {1'b0, sat32(n_v2), sat32(n_v1), sat32(n_v0),
                               r_p5_ang.yaw, r_p5_ang.pitch, r_p5_ang.roll};
        end
    end

endmodule
`default_nettype wire

FILE: src/qaa_check.sv
`timescale 1ns / 1ps
`default_nettype none
module qaa_check (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [143:0] o_m_axis_tdata
);

    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    assign pitch = $signed(o_m_axis_tdata[30:16]);
    assign roll  = $signed(o_m_axis_tdata[15:0]);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output stall");

    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> pitch >= -15'sd12868 && pitch <= 15'sd12868)
        else $error("pitch out of range");

    a_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> roll >= -16'sd25736 && roll <= 16'sd25736)
        else $error("roll out of range");

endmodule

bind quadrotor_attitude_acceleration qaa_check u_qaa_check (.*);
`default_nettype wire

FILE: test/qaa_checker.sv
`timescale 1ns / 1ps
module qaa_checker
    import qaa_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_valid,
    input  wire logic         i_s_ready,
    input  wire logic [127:0] i_s_data,
    input  wire logic         i_m_valid,
    input  wire logic         i_m_ready,
    input  wire logic [143:0] i_m_data,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [23:0]  i_cfg_data,
    output int                o_fails,
    output int                o_pending
);

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
    } t_attitude;

    localparam longint ONE_Q28 = 64'sd1 <<< 28;
    localparam longint PI_RAD  = 3294199;
    localparam longint HALF_PI = 1647099;
    localparam longint K_Q30   = 652032874;
    localparam longint ARC_Q20 [20] = '{823550, 486170, 256879, 130396, 65451, 32757,
        16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

    logic [23:0] inv_mass_q;
    logic [15:0] gain_q;
    logic [20:0] gravity_q;
    t_attitude   attitude_q[$];

    function automatic longint round_sh(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint arc_tan2(longint y, longint x);
        longint z;
        longint nx;
        longint ny;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_RAD : -PI_RAD;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 20; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ARC_Q20[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ARC_Q20[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic void sin_cos_q30(longint a, output longint s, output longint c);
        bit     flip;
        longint x;
        longint y;
        longint nx;
        longint ny;
        flip = 0;
        x = K_Q30;
        y = 0;
        if (a > HALF_PI) begin
            a -= PI_RAD;
            flip = 1;
        end else if (a < -HALF_PI) begin
            a += PI_RAD;
            flip = 1;
        end
        for (int i = 0; i < 20; i++) begin
            if (a >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                a -= ARC_Q20[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                a += ARC_Q20[i];
            end
            x = nx;
            y = ny;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic t_attitude predict_attitude(logic [127:0] d);
        t_attitude       e;
        longint          w, x, y, z, roll, yaw, t, sq_s, sq_c, p21, p20;
        longint          sr, cr, sp, cp, sy, cy, crsp, a16, v;
        longint          col[3];
        longint unsigned csum, accm;
        w = longint'($signed(d[15:0]));
        x = longint'($signed(d[31:16]));
        y = longint'($signed(d[47:32]));
        z = longint'($signed(d[63:48]));
        roll = arc_tan2(2 * (w * x + y * z), ONE_Q28 - 2 * (x * x + y * y));
        yaw  = arc_tan2(2 * (w * z + x * y), ONE_Q28 - 2 * (y * y + z * z));
        t    = clip(w * y - x * z, -(ONE_Q28 / 2), ONE_Q28 / 2);
        sq_s = floor_sqrt(longint'(unsigned'(ONE_Q28 + 2 * t)) << 28);
        sq_c = floor_sqrt(longint'(unsigned'(ONE_Q28 - 2 * t)) << 28);
        p21  = 4 * arc_tan2(sq_s, sq_c) - PI_RAD;
        p20  = round_sh(p21, 1);
        sin_cos_q30(roll, sr, cr);
        sin_cos_q30(p20, sp, cp);
        sin_cos_q30(yaw, sy, cy);
        crsp   = round_sh(cr * sp, 30);
        col[0] = round_sh(round_sh(sr * sy + crsp * cy, 30), 6);
        col[1] = round_sh(round_sh(-(sr * cy) + crsp * sy, 30), 6);
        col[2] = round_sh(round_sh(cr * cp, 30), 6);
        csum = d[79:64] + d[95:80] + d[111:96] + d[127:112];
        accm = csum * gain_q * inv_mass_q;
        a16  = longint'((accm + (64'd1 << 23)) >> 24);
        e.roll  = 16'(clip(round_sh(roll, 7), -25736, 25736));
        e.pitch = 15'(clip(round_sh(p21, 8), -12868, 12868));
        e.yaw   = 16'(clip(round_sh(yaw, 7), -25736, 25736));
        v = round_sh(a16 * col[0], 24);
        e.acc_x = 32'(clip(v, -64'sd2147483648, 64'sd2147483647));
        v = round_sh(a16 * col[1], 24);
        e.acc_y = 32'(clip(v, -64'sd2147483648, 64'sd2147483647));
        v = round_sh(a16 * col[2], 24) - longint'(gravity_q);
        e.acc_z = 32'(clip(v, -64'sd2147483648, 64'sd2147483647));
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_attitude e;
        t_attitude a;
        if (!i_rst_n) begin
            inv_mass_q = 24'd65536;
            gain_q     = 16'd4096;
            gravity_q  = 21'd642908;
            attitude_q.delete();
            o_pending  = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INV_MASS:    inv_mass_q = i_cfg_data;
                    REG_THRUST_GAIN: gain_q     = i_cfg_data[15:0];
                    REG_GRAVITY:     gravity_q  = i_cfg_data[20:0];
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready) attitude_q.push_back(predict_attitude(i_s_data));
            if (i_m_valid && i_m_ready) begin
                a.roll  = i_m_data[15:0];
                a.pitch = i_m_data[30:16];
                a.yaw   = i_m_data[46:31];
                a.acc_x = i_m_data[78:47];
                a.acc_y = i_m_data[110:79];
                a.acc_z = i_m_data[142:111];
                if (attitude_q.size() == 0) begin
                    if (o_fails < 10) $display("unexpected result item %p", a);
                    o_fails++;
                end else begin
                    e = attitude_q.pop_front();
                    if (e.roll !== a.roll || e.pitch !== a.pitch || e.yaw !== a.yaw
                        || e.acc_x !== a.acc_x || e.acc_y !== a.acc_y
                        || e.acc_z !== a.acc_z) begin
                        if (o_fails < 10) $display("mismatch: exp %p got %p", e, a);
                        o_fails++;
                    end
                end
            end
            o_pending = attitude_q.size();
        end
    end

endmodule

FILE: test/tb_quadrotor_attitude_acceleration.sv
`timescale 1ns / 1ps
module tb_quadrotor_attitude_acceleration;
    import qaa_pkg::*;

    localparam int LIMIT = 1000000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [143:0] o_m_axis_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [23:0]  i_cfg_data;

    int fails;
    int pending;
    int cycles;
    int gap_max;
    int hold_req;
    int hold_seen;
    int stall;

    quadrotor_attitude_acceleration u_top (.*);

    qaa_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(i_s_axis_tvalid), .i_s_ready(o_s_axis_tready), .i_s_data(i_s_axis_tdata),
        .i_m_valid(o_m_axis_tvalid), .i_m_ready(i_m_axis_tready), .i_m_data(o_m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fails(fails), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("quadrotor_attitude_acceleration verification failed");
            $finish;
        end
    end

    // output side: random stall per item, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall = 0;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) stall = $urandom_range(0, gap_max);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                stall = 400;
            end
            i_m_axis_tready <= (stall == 0);
            if (stall > 0) stall--;
        end
    end

    function automatic logic [127:0] pack_item(logic [15:0] w, logic [15:0] x,
                                               logic [15:0] y, logic [15:0] z,
                                               logic [15:0] c0, logic [15:0] c1,
                                               logic [15:0] c2, logic [15:0] c3);
        return {c3, c2, c1, c0, z, y, x, w};
    endfunction

    function automatic logic [15:0] rand_comp();
        if ($urandom_range(0, 1)) return 16'($urandom);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [15:0] rand_cmd();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 8192));
    endfunction

    task automatic send_item(logic [127:0] d);
        int g;
        g = $urandom_range(0, gap_max);
        if (g > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_config(logic [23:0] inv, logic [15:0] gain, logic [20:0] grav);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_INV_MASS;
        i_cfg_data <= inv;
        @(posedge i_clk);
        i_cfg_idx  <= REG_THRUST_GAIN;
        i_cfg_data <= 24'(gain);
        @(posedge i_clk);
        i_cfg_idx  <= REG_GRAVITY;
        i_cfg_data <= 24'(grav);
        @(posedge i_clk);
        i_cfg_idx  <= 2'd3;
        i_cfg_data <= 24'($urandom);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_directed();
        send_item(pack_item(0, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_item(16384, 0, 0, 0, 4096, 4096, 4096, 4096));
        send_item(pack_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, '1, '1, '1, '1));
        send_item(pack_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, '1, 0, '1, 0));
        send_item(pack_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0, '1, 0, '1));
        send_item(pack_item(11585, 0, 11585, 0, 1000, 2000, 3000, 4000));
        send_item(pack_item(11585, 0, -16'sd11585, 0, 500, 500, 500, 500));
        send_item(pack_item(16384, 0, 16384, 0, 100, 0, 0, 0));
        send_item(pack_item(0, 0, 0, 16384, 4096, 0, 0, 0));
        send_item(pack_item(0, 16384, 0, 0, 0, 4096, 0, 0));
        send_item(pack_item(0, 0, 16384, 0, 0, 0, 4096, 0));
        send_item(pack_item(0, -16'sd16384, 0, 0, 0, 0, 0, 4096));
        send_item(pack_item(-16'sd16384, 0, 0, 1, 8192, 8192, 8192, 8192));
        send_item(pack_item(0, 0, 0, -16'sd1, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        send_item(pack_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1, 1, 1, 1));
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i == n / 3) gap_max = 0;
            if (i == n / 3 + 40) gap_max = 18;
            send_item(pack_item(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                                rand_cmd(), rand_cmd(), rand_cmd(), rand_cmd()));
        end
    endtask

    initial begin
        hold_req  = 0;
        gap_max   = 18;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        send_random(200);
        settle();

        set_config(24'd1, 16'd0, 21'd0);
        hold_req++;
        send_random(200);
        settle();

        set_config(24'hFFFFFF, 16'hFFFF, 21'h1FFFFF);
        send_directed();
        send_random(150);
        settle();

        set_config(24'd0, 16'd4096, 21'd642908);
        send_random(150);
        settle();

        set_config(24'd65536, 16'd4096, 21'd642908);
        hold_req++;
        send_random(200);
        settle();

        for (int p = 0; p < 3; p++) begin
            set_config(24'($urandom_range(1, 24'hFFFFFF)), 16'($urandom),
                       21'($urandom_range(0, 21'h1FFFFF)));
            send_random(100);
            settle();
        end

        if (fails == 0) begin
            $display("quadrotor_attitude_acceleration verification clean");
        end else begin
            $display("quadrotor_attitude_acceleration verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/qaa_pkg.sv
src/quadrotor_attitude_acceleration.sv
src/qaa_check.sv
test/qaa_checker.sv
test/tb_quadrotor_attitude_acceleration.sv
